// ===== rtl/heater_pid_with_fan_hysteresis_assert.svh =====
// Assertion macros shared by the heater PID controller RTL.
`ifndef HEATER_PID_WITH_FAN_HYSTERESIS_ASSERT_SVH
`define HEATER_PID_WITH_FAN_HYSTERESIS_ASSERT_SVH

// Generic clocked assertion with asynchronous active-low reset disable.
`define HPHF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("hphf assertion failed");

// Shorthand on the block's own clock and reset.
`define HPHF_ASSERT_CLK(lbl, prop) `HPHF_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

// ===== rtl/hphf_pkg.sv =====
// Package: shared constants, register codes and types of the heater PID controller.
`timescale 1ns / 1ps
package hphf_pkg;

  // Parameter defaults
  localparam int TEMP_WIDTH_DEF   = 14;
  localparam int GAIN_WIDTH_DEF   = 16;
  localparam int SAMPLE_TICKS_DEF = 10;

  // Temperatures in 1/16 C
  localparam int FAN_OFF_BELOW = 720;   // 45 C
  localparam int FAN_ON_ABOVE  = 880;   // 55 C
  localparam int BANG_RANGE    = 320;   // 20 C
  localparam int INTEG_RANGE   = 160;   // 10 C
  localparam int INTEG_MIN     = 800;   // 50 C
  localparam int INTEG_MAX     = 8000;  // 500 C
  localparam int CEIL_RESET    = 4320;  // 270 C

  // Integral accumulator fits 0..8191
  localparam int INTEG_W = 13;
  // Error inside the PID band (-320..320) fits this signed width
  localparam int ERR_W   = 10;

  // Duty scaling: sum is in units of 1/40960 step = (1/4096) * (1/10)
  localparam int DUTY_W      = 8;
  localparam int DUTY_MAX    = 255;
  localparam int DUTY_SHIFT  = 12;
  localparam int SAT_LIMIT   = 2560;  // 256 * 10, first saturating value after shift
  localparam int QUOT_W      = 12;    // shifted sum below SAT_LIMIT
  localparam int RECIP_TEN   = 6554;  // ceil(65536 / 10)
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_TEMP  = 3'd0,
    REG_TARGET_FLOOR = 3'd1,
    REG_TEMP_CEILING = 3'd2,
    REG_PROP_GAIN    = 3'd3,
    REG_INTEG_GAIN   = 3'd4,
    REG_DERIV_GAIN   = 3'd5
  } cfg_reg_e;

  // How the heater level of a tick is decided
  typedef enum logic [1:0] {
    HEAT_OFF,
    HEAT_FULL,
    HEAT_PID
  } heat_mode_e;

  // Per-tick control travelling with the datapath
  typedef struct packed {
    heat_mode_e              mode;
    logic [DUTY_W-1:0]       fan;
  } stage_ctl_t;

endpackage

// ===== rtl/hphf_cfg.sv =====
// Configuration register file; gains for P and D are stored pre-multiplied by ten.
`timescale 1ns / 1ps
module hphf_cfg #(
  parameter int TEMP_WIDTH = hphf_pkg::TEMP_WIDTH_DEF,
  parameter int GAIN_WIDTH = hphf_pkg::GAIN_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  wr_en_i,
  input  logic [hphf_pkg::CFG_IDX_W-1:0]        wr_index_i,
  input  logic [((TEMP_WIDTH > GAIN_WIDTH) ? TEMP_WIDTH : GAIN_WIDTH)-1:0] wr_data_i,
  output logic signed [TEMP_WIDTH-1:0]          target_o,
  output logic signed [TEMP_WIDTH-1:0]          floor_o,
  output logic signed [((TEMP_WIDTH > 14) ? TEMP_WIDTH : 14):0] ceiling_o,
  output logic [GAIN_WIDTH+3:0]                 kp10_o,
  output logic [GAIN_WIDTH-1:0]                 ki_o,
  output logic [GAIN_WIDTH+3:0]                 kd10_o
);

  localparam int EW = ((TEMP_WIDTH > 14) ? TEMP_WIDTH : 14) + 1;
  localparam int KW = GAIN_WIDTH + 4;

  logic signed [TEMP_WIDTH-1:0] target_q, floor_q;
  logic signed [EW-1:0]         ceiling_q;
  logic [KW-1:0]                kp10_q, kd10_q;
  logic [GAIN_WIDTH-1:0]        ki_q;
  logic signed [TEMP_WIDTH-1:0] wr_temp;
  logic [GAIN_WIDTH-1:0]        wr_gain;
  logic [KW-1:0]                wr_gain10;

  // Low bits of the write data, and gain times ten as 8x + 2x
  assign wr_temp   = $signed(wr_data_i[TEMP_WIDTH-1:0]);
  assign wr_gain   = wr_data_i[GAIN_WIDTH-1:0];
  assign wr_gain10 = {1'b0, wr_gain, 3'b000} + {3'b000, wr_gain, 1'b0};

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= '0;
      floor_q   <= '0;
      ceiling_q <= EW'(hphf_pkg::CEIL_RESET);
      kp10_q    <= '0;
      ki_q      <= '0;
      kd10_q    <= '0;
    end else if (wr_en_i) begin
      unique case (hphf_pkg::cfg_reg_e'(wr_index_i))
        hphf_pkg::REG_TARGET_TEMP:  target_q  <= wr_temp;
        hphf_pkg::REG_TARGET_FLOOR: floor_q   <= wr_temp;
        hphf_pkg::REG_TEMP_CEILING: ceiling_q <= EW'(wr_temp);
        hphf_pkg::REG_PROP_GAIN:    kp10_q    <= wr_gain10;
        hphf_pkg::REG_INTEG_GAIN:   ki_q      <= wr_gain;
        hphf_pkg::REG_DERIV_GAIN:   kd10_q    <= wr_gain10;
        default: ;
      endcase
    end
  end

  assign target_o  = target_q;
  assign floor_o   = floor_q;
  assign ceiling_o = ceiling_q;
  assign kp10_o    = kp10_q;
  assign ki_o      = ki_q;
  assign kd10_o    = kd10_q;

endmodule

// ===== rtl/hphf_step.sv =====
// Per-tick state update (fan, integral, sample latch) and the three PID products.
`timescale 1ns / 1ps
module hphf_step #(
  parameter int TEMP_WIDTH   = hphf_pkg::TEMP_WIDTH_DEF,
  parameter int GAIN_WIDTH   = hphf_pkg::GAIN_WIDTH_DEF,
  parameter int SAMPLE_TICKS = hphf_pkg::SAMPLE_TICKS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  ld_i,
  input  logic signed [TEMP_WIDTH-1:0]          cur_i,
  input  logic signed [TEMP_WIDTH-1:0]          target_i,
  input  logic signed [TEMP_WIDTH-1:0]          floor_i,
  input  logic signed [((TEMP_WIDTH > 14) ? TEMP_WIDTH : 14):0] ceiling_i,
  input  logic [GAIN_WIDTH+3:0]                 kp10_i,
  input  logic [GAIN_WIDTH-1:0]                 ki_i,
  input  logic [GAIN_WIDTH+3:0]                 kd10_i,
  output logic signed [GAIN_WIDTH+4+hphf_pkg::ERR_W:0] p10_o,
  output logic signed [GAIN_WIDTH+5+TEMP_WIDTH:0]      d10_o,
  output logic [GAIN_WIDTH+hphf_pkg::INTEG_W-1:0]      i_o,
  output hphf_pkg::stage_ctl_t                         ctl_o
);

  localparam int EW  = ((TEMP_WIDTH > 14) ? TEMP_WIDTH : 14) + 1;
  localparam int KW  = GAIN_WIDTH + 4;
  localparam int ERW = hphf_pkg::ERR_W;
  localparam int IW  = hphf_pkg::INTEG_W;
  localparam int SUW = IW + 2;                    // signed integral sum before clamp
  localparam int PW  = KW + 1 + ERW;
  localparam int DW  = KW + 1 + TEMP_WIDTH + 1;
  localparam int QW  = GAIN_WIDTH + IW;
  localparam int TW  = $clog2(SAMPLE_TICKS);

  // State
  logic [hphf_pkg::DUTY_W-1:0]   fan_q, fan_d;
  logic [IW-1:0]                 integ_q, integ_d;
  logic [TW-1:0]                 tick_q, tick_d;
  logic signed [TEMP_WIDTH-1:0]  older_q, older_d, newer_q, newer_d;

  // Result registers toward the sum stage
  logic signed [PW-1:0]          p10_q;
  logic signed [DW-1:0]          d10_q;
  logic [QW-1:0]                 i_q;
  hphf_pkg::stage_ctl_t          ctl_q, ctl_d;

  logic signed [EW-1:0]          cur_e, tgt_e, flr_e, err;
  logic                          early_off, bang_hi, bang_lo, in_integ;
  logic signed [ERW-1:0]         err_n;
  logic signed [SUW-1:0]         integ_sum;
  logic [IW-1:0]                 integ_clamp;
  logic signed [TEMP_WIDTH:0]    sdiff;
  logic signed [PW-1:0]          p10_d;
  logic signed [DW-1:0]          d10_d;
  logic [QW-1:0]                 i_d;

  // Widened temperatures and control error
  assign cur_e = EW'(cur_i);
  assign tgt_e = EW'(target_i);
  assign flr_e = EW'(floor_i);
  assign err   = tgt_e - cur_e;
  assign err_n = err[ERW-1:0];

  // Region decode
  assign early_off = (tgt_e < flr_e) || (cur_e > ceiling_i);
  assign bang_hi   = err > EW'(hphf_pkg::BANG_RANGE);
  assign bang_lo   = err < -EW'(hphf_pkg::BANG_RANGE);
  assign in_integ  = (err >= -EW'(hphf_pkg::INTEG_RANGE)) &&
                     (err < EW'(hphf_pkg::INTEG_RANGE));

  // Fan hysteresis: full-on check wins over the off check
  always_comb begin
    fan_d = fan_q;
    if (cur_e > EW'(hphf_pkg::FAN_ON_ABOVE)) begin
      fan_d = hphf_pkg::DUTY_W'(hphf_pkg::DUTY_MAX);
    end else if ((cur_e < EW'(hphf_pkg::FAN_OFF_BELOW)) &&
                 (tgt_e < EW'(hphf_pkg::FAN_OFF_BELOW))) begin
      fan_d = '0;
    end
  end

  // Integral accumulate and clamp to 50..500 C
  always_comb begin
    integ_sum = $signed({2'b00, integ_q}) + (in_integ ? SUW'(err_n) : '0);
    if (integ_sum < SUW'(hphf_pkg::INTEG_MIN)) begin
      integ_clamp = IW'(hphf_pkg::INTEG_MIN);
    end else if (integ_sum > SUW'(hphf_pkg::INTEG_MAX)) begin
      integ_clamp = IW'(hphf_pkg::INTEG_MAX);
    end else begin
      integ_clamp = integ_sum[IW-1:0];
    end
  end

  // Heater mode and integral next value
  always_comb begin
    integ_d    = integ_q;
    ctl_d.fan  = fan_d;
    ctl_d.mode = hphf_pkg::HEAT_PID;
    priority if (early_off) begin
      ctl_d.mode = hphf_pkg::HEAT_OFF;
    end else if (bang_hi) begin
      ctl_d.mode = hphf_pkg::HEAT_FULL;
      integ_d    = '0;
    end else if (bang_lo) begin
      ctl_d.mode = hphf_pkg::HEAT_OFF;
      integ_d    = '0;
    end else begin
      integ_d    = integ_clamp;
    end
  end

  // Tick counter and derivative sample latch
  always_comb begin
    tick_d  = tick_q;
    older_d = older_q;
    newer_d = newer_q;
    if (!early_off) begin
      if (tick_q == TW'(SAMPLE_TICKS - 1)) begin
        tick_d  = '0;
        older_d = newer_q;
        newer_d = cur_i;
      end else begin
        tick_d  = tick_q + TW'(1);
      end
    end
  end

  // PID products, samples taken before this tick's latch
  assign sdiff = (TEMP_WIDTH+1)'(older_q) - (TEMP_WIDTH+1)'(newer_q);
  assign p10_d = PW'($signed({1'b0, kp10_i})) * PW'(err_n);
  assign d10_d = DW'($signed({1'b0, kd10_i})) * DW'(sdiff);
  assign i_d   = QW'(ki_i) * QW'(integ_clamp);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fan_q   <= '0;
      integ_q <= '0;
      tick_q  <= '0;
      older_q <= '0;
      newer_q <= '0;
    end else if (ld_i) begin
      fan_q   <= fan_d;
      integ_q <= integ_d;
      tick_q  <= tick_d;
      older_q <= older_d;
      newer_q <= newer_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      p10_q <= p10_d;
      d10_q <= d10_d;
      i_q   <= i_d;
      ctl_q <= ctl_d;
    end
  end

  assign p10_o = p10_q;
  assign d10_o = d10_q;
  assign i_o   = i_q;
  assign ctl_o = ctl_q;

endmodule

// ===== rtl/hphf_sum.sv =====
// PID sum, scaling by 1/4096 and saturation detect.
`timescale 1ns / 1ps
module hphf_sum #(
  parameter int TEMP_WIDTH = hphf_pkg::TEMP_WIDTH_DEF,
  parameter int GAIN_WIDTH = hphf_pkg::GAIN_WIDTH_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         ld_i,
  input  logic signed [GAIN_WIDTH+4+hphf_pkg::ERR_W:0] p10_i,
  input  logic signed [GAIN_WIDTH+5+TEMP_WIDTH:0]      d10_i,
  input  logic [GAIN_WIDTH+hphf_pkg::INTEG_W-1:0]      i_i,
  input  hphf_pkg::stage_ctl_t                         ctl_i,
  output hphf_pkg::stage_ctl_t                         ctl_o,
  output logic                                         neg_o,
  output logic                                         sat_o,
  output logic [hphf_pkg::QUOT_W-1:0]                  quot_o
);

  localparam int SW = GAIN_WIDTH + TEMP_WIDTH + 8;
  localparam int HW = SW - hphf_pkg::DUTY_SHIFT;

  logic signed [SW-1:0]          s;
  logic [HW-1:0]                 s_hi;
  hphf_pkg::stage_ctl_t          ctl_q;
  logic                          neg_q, sat_q;
  logic [hphf_pkg::QUOT_W-1:0]   quot_q;

  // Three-term sum in 1/40960 duty steps
  assign s    = SW'(p10_i) + SW'(d10_i) + $signed({{(SW-$bits(i_i)){1'b0}}, i_i});
  assign s_hi = s[SW-1:hphf_pkg::DUTY_SHIFT];

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      ctl_q  <= ctl_i;
      neg_q  <= s[SW-1];
      sat_q  <= !s[SW-1] && (s_hi >= HW'(hphf_pkg::SAT_LIMIT));
      quot_q <= s_hi[hphf_pkg::QUOT_W-1:0];
    end
  end

  assign ctl_o  = ctl_q;
  assign neg_o  = neg_q;
  assign sat_o  = sat_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/hphf_scale.sv =====
// Divide by ten via reciprocal, select final heater level, result register.
`timescale 1ns / 1ps
module hphf_scale (
  input  logic                               clk_i,
  input  logic                               ld_i,
  input  hphf_pkg::stage_ctl_t               ctl_i,
  input  logic                               neg_i,
  input  logic                               sat_i,
  input  logic [hphf_pkg::QUOT_W-1:0]        quot_i,
  output logic [hphf_pkg::DUTY_W-1:0]        heater_o,
  output logic [hphf_pkg::DUTY_W-1:0]        fan_o,
  output logic                               band_o
);

  localparam int PRW = hphf_pkg::QUOT_W + hphf_pkg::RECIP_W;

  logic [PRW-1:0]                 prod;
  logic [hphf_pkg::DUTY_W-1:0]    pid_lvl, heater_d;
  logic [hphf_pkg::DUTY_W-1:0]    heater_q, fan_q;
  logic                           band_q;

  // floor(x / 10) for x below 2560
  assign prod    = PRW'(quot_i) * PRW'(hphf_pkg::RECIP_TEN);
  assign pid_lvl = prod[hphf_pkg::RECIP_SHIFT +: hphf_pkg::DUTY_W];

  always_comb begin
    unique case (ctl_i.mode)
      hphf_pkg::HEAT_FULL: heater_d = hphf_pkg::DUTY_W'(hphf_pkg::DUTY_MAX);
      hphf_pkg::HEAT_PID: begin
        priority if (neg_i) heater_d = '0;
        else if (sat_i)     heater_d = hphf_pkg::DUTY_W'(hphf_pkg::DUTY_MAX);
        else                heater_d = pid_lvl;
      end
      default:             heater_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      heater_q <= heater_d;
      fan_q    <= ctl_i.fan;
      band_q   <= (ctl_i.mode == hphf_pkg::HEAT_PID);
    end
  end

  assign heater_o = heater_q;
  assign fan_o    = fan_q;
  assign band_o   = band_q;

endmodule

// ===== rtl/heater_pid_with_fan_hysteresis.sv =====
// Top level: heater PID controller with fan hysteresis, stream ports and pipeline control.
//
// Usage:
//   s_axis carries one transaction per 100 ms tick: the measured temperature.
//   m_axis returns exactly one transaction per tick: heater level, fan level and
//   a flag set when the PID branch produced the heater level.
//   The cfg channel writes the six setup registers (target, floor, ceiling and
//   the P, I, D gains); it is always ready and should only be used while no
//   tick is in flight.
// Timing:
//   Four register stages (input, state/products, sum, output) hold a tick in
//   turn; one tick per cycle is taken while m_axis_tready stays high, since
//   the fan, integral and sample state close in one stage.
//   Each stage moves when the next one is empty or moving, so bubbles close up.
// Reset:
//   rst_ni clears the pipeline valids, fan duty, integral, tick counter and
//   derivative samples; registers return to target 0, floor 0, ceiling 270 C
//   and zero gains.
// Backpressure:
//   When m_axis_tready is low the result holds; upstream stages keep filling
//   and s_axis_tready drops only once every stage is occupied.
`timescale 1ns / 1ps
`include "heater_pid_with_fan_hysteresis_assert.svh"
module heater_pid_with_fan_hysteresis #(
  parameter int TEMP_WIDTH   = hphf_pkg::TEMP_WIDTH_DEF,
  parameter int GAIN_WIDTH   = hphf_pkg::GAIN_WIDTH_DEF,
  parameter int SAMPLE_TICKS = hphf_pkg::SAMPLE_TICKS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((TEMP_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,  // [TW-1:0] measured_temp
  // Result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [23:0]                           m_axis_tdata,  // [7:0] heater_level,
                                                               // [15:8] fan_level,
                                                               // [16] in_pid_band
  // Configuration writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [hphf_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [((TEMP_WIDTH > GAIN_WIDTH) ? TEMP_WIDTH : GAIN_WIDTH)-1:0] cfg_data_i
);

  localparam int EW  = ((TEMP_WIDTH > 14) ? TEMP_WIDTH : 14) + 1;
  localparam int KW  = GAIN_WIDTH + 4;
  localparam int PW  = KW + 1 + hphf_pkg::ERR_W;
  localparam int DW  = KW + 1 + TEMP_WIDTH + 1;
  localparam int QW  = GAIN_WIDTH + hphf_pkg::INTEG_W;
  localparam int OPW = 24 - 2 * hphf_pkg::DUTY_W - 1;

  // Configuration
  logic signed [TEMP_WIDTH-1:0]  target, floor_t;
  logic signed [EW-1:0]          ceiling;
  logic [KW-1:0]                 kp10, kd10;
  logic [GAIN_WIDTH-1:0]         ki;

  // Pipeline control
  logic a_v_q, b_v_q, c_v_q, o_v_q;
  logic a_ld, b_ld, c_ld, o_ld;
  logic signed [TEMP_WIDTH-1:0]  a_cur_q;

  // Datapath between stages
  logic signed [PW-1:0]          p10;
  logic signed [DW-1:0]          d10;
  logic [QW-1:0]                 iprod;
  hphf_pkg::stage_ctl_t          b_ctl, c_ctl;
  logic                          c_neg, c_sat;
  logic [hphf_pkg::QUOT_W-1:0]   c_quot;
  logic [hphf_pkg::DUTY_W-1:0]   heater_lvl, fan_lvl;
  logic                          band;

  assign cfg_ready_o = 1'b1;

  hphf_cfg #(
    .TEMP_WIDTH (TEMP_WIDTH),
    .GAIN_WIDTH (GAIN_WIDTH)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .target_o   (target),
    .floor_o    (floor_t),
    .ceiling_o  (ceiling),
    .kp10_o     (kp10),
    .ki_o       (ki),
    .kd10_o     (kd10)
  );

  // Stage advance: a stage loads when it has data and the next is free or moving
  assign o_ld          = c_v_q && (!o_v_q || m_axis_tready);
  assign c_ld          = b_v_q && (!c_v_q || o_ld);
  assign b_ld          = a_v_q && (!b_v_q || c_ld);
  assign s_axis_tready = !a_v_q || b_ld;
  assign a_ld          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      a_v_q <= a_ld || (a_v_q && !b_ld);
      b_v_q <= b_ld || (b_v_q && !c_ld);
      c_v_q <= c_ld || (c_v_q && !o_ld);
      o_v_q <= o_ld || (o_v_q && !m_axis_tready);
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (a_ld) begin
      a_cur_q <= $signed(s_axis_tdata[TEMP_WIDTH-1:0]);
    end
  end

  hphf_step #(
    .TEMP_WIDTH   (TEMP_WIDTH),
    .GAIN_WIDTH   (GAIN_WIDTH),
    .SAMPLE_TICKS (SAMPLE_TICKS)
  ) u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ld_i      (b_ld),
    .cur_i     (a_cur_q),
    .target_i  (target),
    .floor_i   (floor_t),
    .ceiling_i (ceiling),
    .kp10_i    (kp10),
    .ki_i      (ki),
    .kd10_i    (kd10),
    .p10_o     (p10),
    .d10_o     (d10),
    .i_o       (iprod),
    .ctl_o     (b_ctl)
  );

  hphf_sum #(
    .TEMP_WIDTH (TEMP_WIDTH),
    .GAIN_WIDTH (GAIN_WIDTH)
  ) u_sum (
    .clk_i  (clk_i),
    .ld_i   (c_ld),
    .p10_i  (p10),
    .d10_i  (d10),
    .i_i    (iprod),
    .ctl_i  (b_ctl),
    .ctl_o  (c_ctl),
    .neg_o  (c_neg),
    .sat_o  (c_sat),
    .quot_o (c_quot)
  );

  hphf_scale u_scale (
    .clk_i    (clk_i),
    .ld_i     (o_ld),
    .ctl_i    (c_ctl),
    .neg_i    (c_neg),
    .sat_i    (c_sat),
    .quot_i   (c_quot),
    .heater_o (heater_lvl),
    .fan_o    (fan_lvl),
    .band_o   (band)
  );

  assign m_axis_tvalid = o_v_q;
  assign m_axis_tdata  = {OPW'(0), band, fan_lvl, heater_lvl};

  // Outside the PID band the heater is either off or full on
  `HPHF_ASSERT_CLK(a_bang_level, (m_axis_tvalid && !band) |-> (heater_lvl == '0 || heater_lvl == '1))
  // Fan is only ever switched between off and full
  `HPHF_ASSERT_CLK(a_fan_level, m_axis_tvalid |-> (fan_lvl == '0 || fan_lvl == '1))
  // Input stalls only when every stage holds a tick
  `HPHF_ASSERT_CLK(a_stall_full, !s_axis_tready |-> (a_v_q && b_v_q && c_v_q && o_v_q))
  // A sum-stage tick reaches the output in the next cycle when the output is free
  `HPHF_ASSERT_CLK(a_advance, (c_v_q && !o_v_q) |=> o_v_q)

endmodule
